// ===== hw/rtl/jsu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int MaxResults = 4;
    localparam int CntW       = 3;

    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChQuote     = 8'h22;
    localparam logic [7:0] ChSlash     = 8'h2F;
    localparam logic [7:0] ChB         = 8'h62;
    localparam logic [7:0] ChF         = 8'h66;
    localparam logic [7:0] ChN         = 8'h6E;
    localparam logic [7:0] ChR         = 8'h72;
    localparam logic [7:0] ChT         = 8'h74;
    localparam logic [7:0] ChU         = 8'h75;

    localparam logic [5:0] SurHighTag = 6'b110110;
    localparam logic [5:0] SurLowTag  = 6'b110111;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_HEX1,
        MODE_BS2,
        MODE_U2,
        MODE_HEX2
    } mode_t;

    // results caused by one input transaction
    typedef struct packed {
        logic [CntW-1:0]             cnt;
        logic [MaxResults-1:0][7:0]  data;
        logic                        is_error;
        logic                        eos;
    } group_t;

    // returns {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/json_string_unescape_utf8_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// JSON string body unescaper with utf-8 output
// ----------------------------------------------------------------------------
// Takes one string-body byte per transaction and emits the decoded utf-8
// bytes. A byte that yields zero or one result is taken every cycle while m_tready
// is high; a byte that yields several results (up to four, for \u escapes and
// surrogate pairs) holds the result register and the input until the last is taken.
// Any malformed escape produces a single error transaction at string end.
module json_string_unescape_utf8_top
    import jsu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    input  wire logic       s_tlast,   // string_end
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic [1:0]      m_tuser,   // end_of_string, is_error
    output logic            m_tlast    // run_last
);

    group_t grp;
    logic   accept;
    logic   idle;

    assign accept = s_tvalid && s_tready;

    jsu_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .in_byte    (s_tdata),
        .string_end (s_tlast),
        .grp        (grp),
        .idle       (idle)
    );

    jsu_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .grp      (grp),
        .can_load (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // error transaction is always a lone zero byte that ends its string
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[1] && m_tlast && m_tdata == 8'h00))
        else $error("error result malformed");

    // decoder returns to plain copy after a string end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> idle)
        else $error("decoder state not cleared at string end");

    // empty result register never blocks input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // string end is flagged only on the last byte of a group
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("end of string before last result");

endmodule
`default_nettype wire

// ===== hw/rtl/jsu_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_decode
// Escape and surrogate decoder, produces up to four utf-8 bytes per byte in
// ----------------------------------------------------------------------------
module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       string_end,
    output group_t          grp,
    output logic            idle
);

    mode_t       mode_reg,   mode_next;
    logic [15:0] acc_reg,    acc_next;
    logic [1:0]  dcnt_reg,   dcnt_next;
    logic [9:0]  high_reg,   high_next;
    logic        disc_reg,   disc_next;

    logic [4:0]  hv;
    logic [15:0] acc_new;
    logic [20:0] pair_cp;
    logic        err;
    group_t      enc;
    group_t      res;

    function automatic group_t utf8_encode(input logic [20:0] cp);
        group_t g;
        g = '0;
        if (cp < 21'h80) begin
            g.cnt     = 3'd1;
            g.data[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            g.cnt     = 3'd2;
            g.data[0] = {3'b110, cp[10:6]};
            g.data[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            g.cnt     = 3'd3;
            g.data[0] = {4'b1110, cp[15:12]};
            g.data[1] = {2'b10, cp[11:6]};
            g.data[2] = {2'b10, cp[5:0]};
        end else begin
            g.cnt     = 3'd4;
            g.data[0] = {5'b11110, cp[20:18]};
            g.data[1] = {2'b10, cp[17:12]};
            g.data[2] = {2'b10, cp[11:6]};
            g.data[3] = {2'b10, cp[5:0]};
        end
        return g;
    endfunction

    assign hv      = hex_value(in_byte);
    assign acc_new = {acc_reg[11:0], hv[3:0]};
    assign pair_cp = 21'h10000 + {1'b0, high_reg, acc_new[9:0]};

    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        dcnt_next = dcnt_reg;
        high_next = high_reg;
        disc_next = disc_reg;
        err       = 1'b0;
        res       = '0;
        enc       = '0;

        if (disc_reg) begin
            if (string_end) begin
                res.cnt      = 3'd1;
                res.is_error = 1'b1;
                res.eos      = 1'b1;
                mode_next    = MODE_NORMAL;
                acc_next     = '0;
                dcnt_next    = '0;
                high_next    = '0;
                disc_next    = 1'b0;
            end
        end else begin
            unique case (mode_reg)
                MODE_NORMAL: begin
                    if (in_byte == ChBackslash) begin
                        mode_next = MODE_ESC;
                    end else begin
                        enc.cnt     = 3'd1;
                        enc.data[0] = in_byte;
                    end
                end
                MODE_ESC: begin
                    mode_next = MODE_NORMAL;
                    enc.cnt   = 3'd1;
                    case (in_byte)
                        ChQuote, ChBackslash, ChSlash: enc.data[0] = in_byte;
                        ChB: enc.data[0] = 8'h08;
                        ChF: enc.data[0] = 8'h0C;
                        ChN: enc.data[0] = 8'h0A;
                        ChR: enc.data[0] = 8'h0D;
                        ChT: enc.data[0] = 8'h09;
                        ChU: begin
                            enc.cnt   = 3'd0;
                            mode_next = MODE_HEX1;
                            acc_next  = '0;
                            dcnt_next = '0;
                        end
                        default: begin
                            enc.cnt = 3'd0;
                            err     = 1'b1;
                        end
                    endcase
                end
                MODE_HEX1, MODE_HEX2: begin
                    if (!hv[4]) begin
                        err = 1'b1;
                    end else if (dcnt_reg != 2'd3) begin
                        acc_next  = acc_new;
                        dcnt_next = dcnt_reg + 2'd1;
                    end else begin
                        acc_next  = '0;
                        dcnt_next = '0;
                        if (mode_reg == MODE_HEX1) begin
                            if (acc_new[15:10] == SurLowTag) begin
                                err = 1'b1;
                            end else if (acc_new[15:10] == SurHighTag) begin
                                high_next = acc_new[9:0];
                                mode_next = MODE_BS2;
                            end else begin
                                enc       = utf8_encode({5'd0, acc_new});
                                mode_next = MODE_NORMAL;
                            end
                        end else begin
                            if (acc_new[15:10] != SurLowTag) begin
                                err = 1'b1;
                            end else begin
                                enc       = utf8_encode(pair_cp);
                                mode_next = MODE_NORMAL;
                            end
                        end
                    end
                end
                MODE_BS2: begin
                    if (in_byte == ChBackslash) mode_next = MODE_U2;
                    else err = 1'b1;
                end
                MODE_U2: begin
                    if (in_byte == ChU) begin
                        mode_next = MODE_HEX2;
                        acc_next  = '0;
                        dcnt_next = '0;
                    end else begin
                        err = 1'b1;
                    end
                end
                default: err = 1'b1;
            endcase

            if (!err && string_end && mode_next != MODE_NORMAL) err = 1'b1;

            if (err || string_end) begin
                mode_next = MODE_NORMAL;
                acc_next  = '0;
                dcnt_next = '0;
                high_next = '0;
            end

            if (err) begin
                if (string_end) begin
                    res.cnt      = 3'd1;
                    res.is_error = 1'b1;
                    res.eos      = 1'b1;
                end else begin
                    disc_next = 1'b1;
                end
            end else begin
                res     = enc;
                res.eos = string_end;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            acc_reg  <= '0;
            dcnt_reg <= '0;
            high_reg <= '0;
            disc_reg <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            dcnt_reg <= dcnt_next;
            high_reg <= high_next;
            disc_reg <= disc_next;
        end
    end

    assign grp  = res;
    assign idle = (mode_reg == MODE_NORMAL) && !disc_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/jsu_outbuf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_outbuf
// Result register, sends the bytes of one group one transaction at a time
// ----------------------------------------------------------------------------
module jsu_outbuf
    import jsu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire group_t     grp,
    output logic            can_load,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);

    logic [CntW-1:0]            cnt_reg,  cnt_next;
    logic [MaxResults-1:0][7:0] data_reg, data_next;
    logic                       err_reg,  err_next;
    logic                       eos_reg,  eos_next;
    logic                       pop;

    assign pop      = (cnt_reg != '0) && m_tready;
    assign can_load = (cnt_reg == '0) || ((cnt_reg == CntW'(1)) && m_tready);

    always_comb begin
        cnt_next  = cnt_reg;
        data_next = data_reg;
        err_next  = err_reg;
        eos_next  = eos_reg;
        if (load && grp.cnt != '0) begin
            cnt_next  = grp.cnt;
            data_next = grp.data;
            err_next  = grp.is_error;
            eos_next  = grp.eos;
        end else if (pop) begin
            cnt_next  = cnt_reg - CntW'(1);
            data_next = data_reg >> 8;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        err_reg  <= err_next;
        eos_reg  <= eos_next;
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = data_reg[0];
    assign m_tlast  = (cnt_reg == CntW'(1));
    assign m_tuser  = {eos_reg & m_tlast, err_reg};

endmodule
`default_nettype wire

// ===== test/tb_json_string_unescape_utf8_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8_top
// Self-checking bench for the JSON string unescaper with utf-8 output
// ----------------------------------------------------------------------------
// Feeds string bodies byte by byte: a few hand-picked strings, then random
// strings built from plain bytes, simple escapes, \u escapes, surrogate pairs
// and a share of malformed or cut-off escapes. A behavioral decoder tracks
// every accepted byte and queues the utf-8 bytes it should produce; each
// output transaction is checked against the head of that queue. Both sides
// stall at random, with a quiet window, and the sender drains the block
// completely before a few chosen strings.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_top;
    import jsu_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drain;
    } body_t;

    typedef struct packed {
        logic [7:0] data;
        logic       err;
        logic       eos;
        logic       last;
    } res_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    body_t      body_q[$];
    logic [7:0] str_q[$];
    res_t       utf8_q[$];

    // decoder state
    mode_t       mode     = MODE_NORMAL;
    logic [15:0] acc      = '0;
    logic [1:0]  dig_cnt  = '0;
    logic [9:0]  hi_half  = '0;
    logic        dropping = 1'b0;

    int  n_in   = 0;
    int  fails  = 0;
    wire quiet  = (n_in >= 120) && (n_in < 220);

    json_string_unescape_utf8_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic void add_char(input logic [7:0] c);
        str_q.insert(str_q.size(), c);
    endfunction

    function automatic void add_result(input res_t r);
        utf8_q.insert(utf8_q.size(), r);
    endfunction

    // returns {valid, value}
    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        if (b >= "0" && b <= "9") return {1'b1, 4'(b - "0")};
        if (b >= "a" && b <= "f") return {1'b1, 4'(b - "a" + 10)};
        if (b >= "A" && b <= "F") return {1'b1, 4'(b - "A" + 10)};
        return 5'd0;
    endfunction

    function automatic int to_utf8(input logic [20:0] cp, output logic [3:0][7:0] e);
        e = '0;
        if (cp < 21'h80) begin
            e[0] = cp[7:0];
            return 1;
        end
        if (cp < 21'h800) begin
            e[0] = {3'b110, cp[10:6]};
            e[1] = {2'b10, cp[5:0]};
            return 2;
        end
        if (cp < 21'h10000) begin
            e[0] = {4'b1110, cp[15:12]};
            e[1] = {2'b10, cp[11:6]};
            e[2] = {2'b10, cp[5:0]};
            return 3;
        end
        e[0] = {5'b11110, cp[20:18]};
        e[1] = {2'b10, cp[17:12]};
        e[2] = {2'b10, cp[11:6]};
        e[3] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    task automatic clear_string();
        mode     = MODE_NORMAL;
        acc      = '0;
        dig_cnt  = '0;
        hi_half  = '0;
        dropping = 1'b0;
    endtask

    task automatic unescape_byte(input logic [7:0] b, input logic se);
        logic             bad;
        logic [4:0]       d;
        logic [3:0][7:0]  enc;
        int               n;
        bad = 1'b0;
        n   = 0;
        enc = '0;
        if (dropping) begin
            if (se) begin
                add_result('{8'h00, 1'b1, 1'b1, 1'b1});
                clear_string();
            end
            return;
        end
        case (mode)
            MODE_NORMAL: begin
                if (b == ChBackslash) begin
                    mode = MODE_ESC;
                end else begin
                    enc[0] = b;
                    n = 1;
                end
            end
            MODE_ESC: begin
                mode = MODE_NORMAL;
                n = 1;
                case (b)
                    ChQuote, ChBackslash, ChSlash: enc[0] = b;
                    ChB: enc[0] = 8'h08;
                    ChF: enc[0] = 8'h0C;
                    ChN: enc[0] = 8'h0A;
                    ChR: enc[0] = 8'h0D;
                    ChT: enc[0] = 8'h09;
                    ChU: begin
                        n       = 0;
                        mode    = MODE_HEX1;
                        acc     = '0;
                        dig_cnt = '0;
                    end
                    default: begin
                        n   = 0;
                        bad = 1'b1;
                    end
                endcase
            end
            MODE_HEX1, MODE_HEX2: begin
                d = nibble_of(b);
                if (!d[4]) begin
                    bad = 1'b1;
                end else begin
                    acc = {acc[11:0], d[3:0]};
                    if (dig_cnt != 2'd3) begin
                        dig_cnt++;
                    end else begin
                        dig_cnt = '0;
                        if (mode == MODE_HEX1) begin
                            if (acc[15:10] == SurLowTag) begin
                                bad = 1'b1;
                            end else if (acc[15:10] == SurHighTag) begin
                                hi_half = acc[9:0];
                                mode    = MODE_BS2;
                            end else begin
                                n    = to_utf8({5'd0, acc}, enc);
                                mode = MODE_NORMAL;
                            end
                        end else if (acc[15:10] != SurLowTag) begin
                            bad = 1'b1;
                        end else begin
                            n    = to_utf8(21'h10000 + {1'b0, hi_half, acc[9:0]}, enc);
                            mode = MODE_NORMAL;
                        end
                        acc = '0;
                    end
                end
            end
            MODE_BS2: begin
                if (b == ChBackslash) mode = MODE_U2;
                else bad = 1'b1;
            end
            MODE_U2: begin
                if (b == ChU) begin
                    mode    = MODE_HEX2;
                    acc     = '0;
                    dig_cnt = '0;
                end else begin
                    bad = 1'b1;
                end
            end
            default: bad = 1'b1;
        endcase

        // string ends inside an escape
        if (!bad && se && mode != MODE_NORMAL) bad = 1'b1;

        if (bad) begin
            clear_string();
            if (se) add_result('{8'h00, 1'b1, 1'b1, 1'b1});
            else dropping = 1'b1;
            return;
        end
        for (int k = 0; k < n; k++) begin
            add_result('{enc[k], 1'b0, se && (k == n - 1), k == n - 1});
        end
        if (se) clear_string();
    endtask

    // ---- stimulus construction ----

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 10) return 8'(v) + "0";
        return 8'(v - 10) + (($urandom_range(0, 1) == 1) ? "A" : "a");
    endfunction

    task automatic put_u(input logic [15:0] v);
        add_char(ChBackslash);
        add_char(ChU);
        for (int i = 3; i >= 0; i--) add_char(hex_char(v[i*4 +: 4]));
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    task automatic flush_str(input bit drain);
        body_t item;
        for (int i = 0; i < str_q.size(); i++) begin
            item = '{str_q[i], i == str_q.size() - 1, drain && (i == 0)};
            body_q.insert(body_q.size(), item);
        end
        str_q.delete();
    endtask

    task automatic add_token();
        int          kind;
        logic [7:0]  b;
        logic [15:0] v;
        logic [4:0]  d;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            b = 8'($urandom_range(0, 255));
            add_char(b);
            if (b == ChBackslash) add_char(b);
        end else if (kind < 50) begin
            case ($urandom_range(0, 7))
                0:       b = ChQuote;
                1:       b = ChBackslash;
                2:       b = ChSlash;
                3:       b = ChB;
                4:       b = ChF;
                5:       b = ChN;
                6:       b = ChR;
                default: b = ChT;
            endcase
            add_char(ChBackslash);
            add_char(b);
        end else if (kind < 68) begin
            case ($urandom_range(0, 2))
                0:       v = 16'($urandom_range(16'h0000, 16'h007F));
                1:       v = 16'($urandom_range(16'h0080, 16'h07FF));
                default: v = 16'($urandom_range(16'h0800, 16'hFFFF));
            endcase
            // keep clear of the surrogate range
            if (v[15:11] == 5'b11011) v[14] = 1'b0;
            put_u(v);
        end else if (kind < 88) begin
            put_u({SurHighTag, 10'($urandom_range(0, 1023))});
            put_u({SurLowTag, 10'($urandom_range(0, 1023))});
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    // unknown escape letter
                    do b = 8'($urandom_range(0, 255));
                    while (b inside {ChQuote, ChBackslash, ChSlash, ChB, ChF, ChN, ChR, ChT,
                                     ChU});
                    add_char(ChBackslash);
                    add_char(b);
                end
                1: begin
                    // non-hex digit inside a \u group
                    add_char(ChBackslash);
                    add_char(ChU);
                    repeat ($urandom_range(0, 3)) add_char(hex_char(4'($urandom_range(0, 15))));
                    do begin
                        b = 8'($urandom_range(0, 255));
                        d = nibble_of(b);
                    end while (d[4]);
                    add_char(b);
                end
                2: put_u({SurLowTag, 10'($urandom_range(0, 1023))});
                default: begin
                    // high surrogate without a proper low half
                    put_u({SurHighTag, 10'($urandom_range(0, 1023))});
                    case ($urandom_range(0, 2))
                        0: begin
                            b = 8'($urandom_range(0, 255));
                            if (b == ChBackslash) b = ChU;
                            add_char(b);
                        end
                        1: begin
                            b = 8'($urandom_range(0, 255));
                            if (b == ChU) b = ChBackslash;
                            add_char(ChBackslash);
                            add_char(b);
                        end
                        default: begin
                            v = 16'($urandom_range(0, 16'hFFFF));
                            if (v[15:10] == SurLowTag) v[15] = 1'b0;
                            put_u(v);
                        end
                    endcase
                end
            endcase
        end
    endtask

    task automatic add_random_string(input bit drain);
        int keep;
        repeat ($urandom_range(1, 5)) add_token();
        if ($urandom_range(0, 99) < 8) begin
            // cut the string off somewhere inside a surrogate pair
            keep = str_q.size() + $urandom_range(1, 11);
            put_u({SurHighTag, 10'($urandom_range(0, 1023))});
            put_u({SurLowTag, 10'($urandom_range(0, 1023))});
            while (str_q.size() > keep) void'(str_q.pop_back());
        end
        flush_str(drain);
    endtask

    // ---- driver ----

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                unescape_byte(s_tdata, s_tlast);
                n_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (body_q.size() != 0 && !(body_q[0].drain && utf8_q.size() != 0) &&
                    (quiet || $urandom_range(0, 99) >= 10)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= body_q[0].data;
                    s_tlast  <= body_q[0].last;
                    void'(body_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---- receiver and monitor ----

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= quiet || ($urandom_range(0, 99) >= 10);
    end

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata, m_tuser[0], m_tuser[1], m_tlast};
            if (utf8_q.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("%0t: unexpected transaction byte %02h err %0b eos %0b last %0b",
                             $realtime, got.data, got.err, got.eos, got.last);
            end else begin
                want = utf8_q.pop_front();
                if (got !== want) begin
                    fails++;
                    if (fails <= 10)
                        $display({"%0t: expected byte %02h err %0b eos %0b last %0b, ",
                                  "got %02h %0b %0b %0b"},
                                 $realtime, want.data, want.err, want.eos, want.last,
                                 got.data, got.err, got.eos, got.last);
                end
            end
        end
    end

    // ---- sequence ----

    initial begin
        int strings;
        int total;
        add_char(8'h00);
        add_char(8'hFF);
        flush_str(1'b0);
        add_text("\\u0000");
        flush_str(1'b0);
        add_text("\\uD83D\\uDE00");
        flush_str(1'b0);
        // unknown escape on the final byte
        add_text("\\q");
        flush_str(1'b0);
        // string ends right after a backslash
        add_text("\\");
        flush_str(1'b0);
        // lone low surrogate, rest of the string dropped
        add_text("\\uDC00x");
        flush_str(1'b1);
        strings = 0;
        while (body_q.size() < 300) begin
            add_random_string(strings % 25 == 12);
            strings++;
        end
        total = body_q.size();

        while (n_in < total) @(posedge aclk);
        while (utf8_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
